// ===== sv/quadrature_count_speed_estimator_macros.svh =====
// assertion macros for the quadrature count speed estimator
`ifndef QUADRATURE_COUNT_SPEED_ESTIMATOR_MACROS_SVH
`define QUADRATURE_COUNT_SPEED_ESTIMATOR_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication under reset
`define QCSE_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("qcse assertion failed");

// next-cycle implication under reset
`define QCSE_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("qcse assertion failed");

`else

`define QCSE_ASSERT_NOW(label, clk, rst_n, cond, prop)
`define QCSE_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

// ===== sv/qcse_pkg.sv =====
package qcse_pkg;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int STEP_W   = 17;
    localparam int TURNS_W  = 16;
    localparam int SPEED_W  = 23;
    localparam int ANGLE_W  = 37;
    localparam int POS_W    = SAMPLE_W + TURNS_W;

    // wrap detection
    localparam int HALF_RANGE = 32767;
    localparam int FULL_RANGE = 65536;

    // moving average defaults and scaling: speed = sum * 1000 / (11 * depth)
    localparam int AVG_DEPTH_DEF = 8;
    localparam int SPEED_NUM     = 1000;
    localparam int SPEED_NUM_W   = 10;
    localparam int SPEED_DEN     = 11;
    localparam int SPD_SHIFT     = 24;
    localparam int SPD_MUL_W     = 31;
    localparam int SPD_Q_W       = SPEED_W - 1;

    // angle scaling: pos * 256 / 11, via floor(2^32 / 11)
    localparam int ANGLE_DIV  = 11;
    localparam int ANG_SHIFT  = 32;
    localparam int ANG_MUL_W  = 29;
    localparam int ANG_Q_W    = 29;
    localparam int FRAC_W     = 8;
    localparam logic [ANG_MUL_W-1:0] ANG_MUL = ANG_MUL_W'((64'd1 << ANG_SHIFT) / ANGLE_DIV);

    // first pipeline word, handed from the front end to the scaler
    typedef struct packed {
        logic signed [STEP_W-1:0]  step;
        logic signed [TURNS_W-1:0] turns;
        logic signed [POS_W-1:0]   pos;
    } s1_word_t;

endpackage

// ===== sv/qcse_if.sv =====
// sample channel
interface qcse_in_if;
    logic                              valid;
    logic                              ready;
    logic [qcse_pkg::SAMPLE_W-1:0]     count_sample;

    modport source (output valid, output count_sample, input ready);
    modport sink (input valid, input count_sample, output ready);
endinterface

// result channel
interface qcse_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [qcse_pkg::STEP_W-1:0]  step;
    logic signed [qcse_pkg::TURNS_W-1:0] turns;
    logic signed [qcse_pkg::SPEED_W-1:0] speed_avg;
    logic signed [qcse_pkg::ANGLE_W-1:0] angle_q8;

    modport source (output valid, output step, output turns, output speed_avg,
                    output angle_q8, input ready);
    modport sink (input valid, input step, input turns, input speed_avg,
                  input angle_q8, output ready);
endinterface

// ===== sv/quadrature_count_speed_estimator.sv =====
// channel   | dir | word
// ----------+-----+-------------------------------------------------
// samples   | in  | count_sample
// results   | out | step, turns, speed_avg, angle_q8
//
// one sample per cycle sustained while results are taken; a result word is offered once its
// sample has passed the front-end register and the scaling stages
// that path is the front-end register and four scaling stages (two of them multiply)
// rst_n clears the last sample, turn count, running sum and every history cell at once
// backpressure on results stalls stage by stage, so empty stages still take samples
`include "quadrature_count_speed_estimator_macros.svh"

module quadrature_count_speed_estimator #(
    parameter int AVG_DEPTH = qcse_pkg::AVG_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    qcse_in_if.sink    samples,
    qcse_out_if.source results
);

    localparam int SUM_W = qcse_pkg::STEP_W + 1 + $clog2(AVG_DEPTH);
    localparam int EXT_W = SUM_W - qcse_pkg::STEP_W;

    // tracking state
    logic [qcse_pkg::SAMPLE_W-1:0]       last_reg, last_next;
    logic signed [qcse_pkg::TURNS_W-1:0] turns_reg, turns_next;
    logic signed [SUM_W-1:0]             sum_reg, sum_next;

    // first pipeline stage
    logic                                s1_valid_reg;
    qcse_pkg::s1_word_t                  s1_word_reg;
    logic signed [SUM_W-1:0]             s1_sum_reg;

    logic                                accept;
    logic                                take;
    logic                                fwd, bwd;
    logic signed [qcse_pkg::STEP_W:0]    diff;
    logic signed [qcse_pkg::STEP_W:0]    step_wide;
    logic signed [qcse_pkg::STEP_W-1:0]  step_new;
    logic signed [qcse_pkg::STEP_W-1:0]  tap [AVG_DEPTH];
    logic signed [qcse_pkg::STEP_W-1:0]  oldest;

    assign samples.ready = !s1_valid_reg || take;
    assign accept        = samples.valid && samples.ready;

    // wrap detection and step correction
    always_comb
    begin
        diff      = $signed({2'b00, samples.count_sample}) - $signed({2'b00, last_reg});
        fwd       = diff < -qcse_pkg::HALF_RANGE;
        bwd       = diff > qcse_pkg::HALF_RANGE;
        step_wide = diff;
        if (fwd)
        begin
            step_wide = diff + (qcse_pkg::STEP_W + 1)'(qcse_pkg::FULL_RANGE);
        end
        else if (bwd)
        begin
            step_wide = diff - (qcse_pkg::STEP_W + 1)'(qcse_pkg::FULL_RANGE);
        end
        step_new   = step_wide[qcse_pkg::STEP_W-1:0];
        turns_next = turns_reg + qcse_pkg::TURNS_W'(fwd) - qcse_pkg::TURNS_W'(bwd);
        last_next  = samples.count_sample;
    end

    // step history line, newest in cell zero
    genvar gi;
    generate
        for (gi = 0; gi < AVG_DEPTH; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                qcse_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (accept),
                    .din   (step_new),
                    .dout  (tap[gi])
                );
            end
            else
            begin : g_body
                qcse_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (accept),
                    .din   (tap[gi-1]),
                    .dout  (tap[gi])
                );
            end
        end
    endgenerate

    assign oldest = tap[AVG_DEPTH-1];

    // running sum: add newest, drop the one leaving the line
    assign sum_next = sum_reg + $signed({{EXT_W{step_new[qcse_pkg::STEP_W-1]}}, step_new})
                              - $signed({{EXT_W{oldest[qcse_pkg::STEP_W-1]}}, oldest});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg     <= '0;
            turns_reg    <= '0;
            sum_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                last_reg  <= last_next;
                turns_reg <= turns_next;
                sum_reg   <= sum_next;
            end
            if (samples.ready)
            begin
                s1_valid_reg <= samples.valid;
            end
        end
    end

    // first stage word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_word_reg.step  <= step_new;
            s1_word_reg.turns <= turns_next;
            s1_word_reg.pos   <= {turns_next, samples.count_sample};
            s1_sum_reg        <= sum_next;
        end
    end

    qcse_scale #(
        .AVG_DEPTH (AVG_DEPTH)
    ) u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s1_valid_reg),
        .in_take  (take),
        .in_word  (s1_word_reg),
        .in_sum   (s1_sum_reg),
        .results  (results)
    );

    // turn count moves by at most one per sample
    `QCSE_ASSERT_NEXT(a_turn_step, clk, rst_n, accept,
        (turns_reg == $past(turns_reg)) || (turns_reg == $past(turns_reg) + 16'sd1) || (turns_reg == $past(turns_reg) - 16'sd1))

    // corrected step stays within -32768 to 32768
    `QCSE_ASSERT_NOW(a_step_range, clk, rst_n, s1_valid_reg,
        ($signed(s1_word_reg.step) >= -17'sd32768) && ($signed(s1_word_reg.step) <= 17'sd32768))

    // tracking state holds between accepted samples
    `QCSE_ASSERT_NEXT(a_state_hold, clk, rst_n, !accept,
        $stable(last_reg) && $stable(sum_reg) && $stable(turns_reg))

    // stage one word matches the tracking state it was taken from
    `QCSE_ASSERT_NEXT(a_s1_track, clk, rst_n, accept,
        (s1_sum_reg == sum_reg) && (s1_word_reg.turns == turns_reg))

endmodule

// ===== sv/qcse_cell.sv =====
// one tap of the step history line
module qcse_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              shift,
    input  logic signed [qcse_pkg::STEP_W-1:0] din,
    output logic signed [qcse_pkg::STEP_W-1:0] dout
);

    logic signed [qcse_pkg::STEP_W-1:0] step_reg;
    logic signed [qcse_pkg::STEP_W-1:0] step_next;

    // take din (the neighbor's step, or the new step at the head) on each accepted word
    always_comb
    begin
        step_next = shift ? din : step_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign dout = step_reg;

endmodule

// ===== sv/qcse_scale.sv =====
// constant scaling of the running sum and the position, four stages
module qcse_scale #(
    parameter int AVG_DEPTH = qcse_pkg::AVG_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_take,
    input  qcse_pkg::s1_word_t          in_word,
    input  logic signed [qcse_pkg::STEP_W + $clog2(AVG_DEPTH):0] in_sum,
    qcse_out_if.source                  results
);

    localparam int SUM_W   = qcse_pkg::STEP_W + 1 + $clog2(AVG_DEPTH);
    localparam int PRS_W   = SUM_W + qcse_pkg::SPD_MUL_W;
    localparam int X_W     = SUM_W + qcse_pkg::SPEED_NUM_W;
    localparam int PRA_W   = qcse_pkg::POS_W + qcse_pkg::ANG_MUL_W;
    localparam int SPD_DIV = qcse_pkg::SPEED_DEN * AVG_DEPTH;
    localparam longint SpdMulL = (64'(qcse_pkg::SPEED_NUM) << qcse_pkg::SPD_SHIFT) / SPD_DIV;
    localparam logic [qcse_pkg::SPD_MUL_W-1:0] SPD_MUL = qcse_pkg::SPD_MUL_W'(SpdMulL);
    localparam logic [X_W-1:0] DIV_X = X_W'(SPD_DIV);
    localparam logic [X_W-1:0] NUM_X = X_W'(qcse_pkg::SPEED_NUM);
    localparam int AR_W = 5;
    localparam logic [AR_W-1:0] ADIV_R = AR_W'(qcse_pkg::ANGLE_DIV);

    // floor(256 * r / 11) for remainders 0 to 10
    function automatic logic [qcse_pkg::FRAC_W-1:0] frac_q8(input logic [3:0] r);
        logic [qcse_pkg::FRAC_W-1:0] f;
        case (r)
            4'd0:    f = 8'd0;
            4'd1:    f = 8'd23;
            4'd2:    f = 8'd46;
            4'd3:    f = 8'd69;
            4'd4:    f = 8'd93;
            4'd5:    f = 8'd116;
            4'd6:    f = 8'd139;
            4'd7:    f = 8'd162;
            4'd8:    f = 8'd186;
            4'd9:    f = 8'd209;
            4'd10:   f = 8'd232;
            default: f = 8'd0;
        endcase
        return f;
    endfunction

    // stage valids and enables
    logic v2_reg, v3_reg, v4_reg, v5_reg;
    logic en2, en3, en4, en5;

    // stage 2: magnitudes
    logic                               neg_s2_reg, neg_a2_reg;
    logic [SUM_W-1:0]                   mag_s2_reg;
    logic [qcse_pkg::POS_W-1:0]         mag_a2_reg;
    logic signed [qcse_pkg::STEP_W-1:0]  step2_reg;
    logic signed [qcse_pkg::TURNS_W-1:0] turns2_reg;

    // stage 3: reciprocal products
    logic                               neg_s3_reg, neg_a3_reg;
    logic [PRS_W-1:0]                   prs3_reg;
    logic [X_W-1:0]                     x3_reg;
    logic [PRA_W-1:0]                   pra3_reg;
    logic [qcse_pkg::POS_W-1:0]         mag_a3_reg;
    logic signed [qcse_pkg::STEP_W-1:0]  step3_reg;
    logic signed [qcse_pkg::TURNS_W-1:0] turns3_reg;

    // stage 4: quotient estimates and back products
    logic                               neg_s4_reg, neg_a4_reg;
    logic [qcse_pkg::SPD_Q_W-1:0]       qs4_reg;
    logic [X_W-1:0]                     x4_reg;
    logic [X_W-1:0]                     qds4_reg;
    logic [qcse_pkg::ANG_Q_W-1:0]       qa4_reg;
    logic [qcse_pkg::POS_W-1:0]         mag_a4_reg;
    logic [qcse_pkg::POS_W-1:0]         qda4_reg;
    logic signed [qcse_pkg::STEP_W-1:0]  step4_reg;
    logic signed [qcse_pkg::TURNS_W-1:0] turns4_reg;

    // stage 5: output word
    logic signed [qcse_pkg::STEP_W-1:0]  step5_reg;
    logic signed [qcse_pkg::TURNS_W-1:0] turns5_reg;
    logic signed [qcse_pkg::SPEED_W-1:0] speed5_reg;
    logic signed [qcse_pkg::ANGLE_W-1:0] angle5_reg;

    // stage 5 next values
    logic signed [qcse_pkg::SPEED_W-1:0] speed5_next;
    logic signed [qcse_pkg::ANGLE_W-1:0] angle5_next;

    // each stage moves when its successor is empty or moving
    assign en5     = !v5_reg || results.ready;
    assign en4     = !v4_reg || en5;
    assign en3     = !v3_reg || en4;
    assign en2     = !v2_reg || en3;
    assign in_take = en2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en2)
            begin
                v2_reg <= in_valid;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
            if (en5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    // magnitudes of sum and position
    always_ff @(posedge clk)
    begin
        if (en2 && in_valid)
        begin
            neg_s2_reg <= in_sum[SUM_W-1];
            mag_s2_reg <= in_sum[SUM_W-1] ? SUM_W'(-in_sum) : SUM_W'(in_sum);
            neg_a2_reg <= in_word.pos[qcse_pkg::POS_W-1];
            mag_a2_reg <= in_word.pos[qcse_pkg::POS_W-1] ? (~in_word.pos + 1'b1)
                                                          : in_word.pos;
            step2_reg  <= in_word.step;
            turns2_reg <= in_word.turns;
        end
    end

    // multiply by the scaled reciprocals
    always_ff @(posedge clk)
    begin
        if (en3 && v2_reg)
        begin
            neg_s3_reg <= neg_s2_reg;
            neg_a3_reg <= neg_a2_reg;
            prs3_reg   <= PRS_W'(mag_s2_reg) * PRS_W'(SPD_MUL);
            x3_reg     <= X_W'(mag_s2_reg) * NUM_X;
            pra3_reg   <= PRA_W'(mag_a2_reg) * PRA_W'(qcse_pkg::ANG_MUL);
            mag_a3_reg <= mag_a2_reg;
            step3_reg  <= step2_reg;
            turns3_reg <= turns2_reg;
        end
    end

    // quotient estimates, low by at most one, and their back products
    always_ff @(posedge clk)
    begin
        if (en4 && v3_reg)
        begin
            neg_s4_reg <= neg_s3_reg;
            neg_a4_reg <= neg_a3_reg;
            qs4_reg    <= prs3_reg[qcse_pkg::SPD_SHIFT +: qcse_pkg::SPD_Q_W];
            qds4_reg   <= X_W'(prs3_reg[qcse_pkg::SPD_SHIFT +: qcse_pkg::SPD_Q_W]) * DIV_X;
            x4_reg     <= x3_reg;
            qa4_reg    <= pra3_reg[qcse_pkg::ANG_SHIFT +: qcse_pkg::ANG_Q_W];
            qda4_reg   <= qcse_pkg::POS_W'(pra3_reg[qcse_pkg::ANG_SHIFT +: qcse_pkg::ANG_Q_W])
                          * qcse_pkg::POS_W'(qcse_pkg::ANGLE_DIV);
            mag_a4_reg <= mag_a3_reg;
            step4_reg  <= step3_reg;
            turns4_reg <= turns3_reg;
        end
    end

    // remainder correction and sign
    always_comb
    begin
        logic [X_W-1:0]                     rs;
        logic [qcse_pkg::SPD_Q_W-1:0]       qs;
        logic [qcse_pkg::POS_W-1:0]         ra_full;
        logic [AR_W-1:0]                    ra;
        logic                               fix_a;
        logic [qcse_pkg::ANG_Q_W-1:0]       qa;
        logic [AR_W-1:0]                    ra_fix;
        logic [qcse_pkg::ANGLE_W-1:0]       mag_a;
        rs      = x4_reg - qds4_reg;
        qs      = qs4_reg + qcse_pkg::SPD_Q_W'(rs >= DIV_X);
        ra_full = mag_a4_reg - qda4_reg;
        ra      = ra_full[AR_W-1:0];
        fix_a   = ra >= ADIV_R;
        qa      = qa4_reg + qcse_pkg::ANG_Q_W'(fix_a);
        ra_fix  = fix_a ? (ra - ADIV_R) : ra;
        mag_a   = {qa, frac_q8(ra_fix[3:0])};
        speed5_next = neg_s4_reg ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
        angle5_next = neg_a4_reg ? -$signed(mag_a) : $signed(mag_a);
    end

    always_ff @(posedge clk)
    begin
        if (en5 && v4_reg)
        begin
            step5_reg  <= step4_reg;
            turns5_reg <= turns4_reg;
            speed5_reg <= speed5_next;
            angle5_reg <= angle5_next;
        end
    end

    assign results.valid     = v5_reg;
    assign results.step      = step5_reg;
    assign results.turns     = turns5_reg;
    assign results.speed_avg = speed5_reg;
    assign results.angle_q8  = angle5_reg;

endmodule

// ===== bench/quadrature_count_speed_estimator_tb.sv =====
`timescale 1ns / 100ps

module quadrature_count_speed_estimator_tb;

    localparam int SAMPLE_W   = qcse_pkg::SAMPLE_W;
    localparam int STEP_W     = qcse_pkg::STEP_W;
    localparam int TURNS_W    = qcse_pkg::TURNS_W;
    localparam int SPEED_W    = qcse_pkg::SPEED_W;
    localparam int ANGLE_W    = qcse_pkg::ANGLE_W;
    localparam int HALF_RANGE = qcse_pkg::HALF_RANGE;
    localparam int FULL_RANGE = qcse_pkg::FULL_RANGE;
    localparam int SPEED_NUM  = qcse_pkg::SPEED_NUM;
    localparam int SPEED_DEN  = qcse_pkg::SPEED_DEN;
    localparam int ANGLE_DIV  = qcse_pkg::ANGLE_DIV;

    localparam int DEPTH        = qcse_pkg::AVG_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 830;
    localparam int CALM_ITEMS   = 150;
    localparam int SPIN_FWD     = 40;
    localparam int SPIN_BACK    = 100;
    localparam int LINGER       = 20;
    localparam int LIMIT_CYCLES = 4000000;

    // shapes of the random motion segments
    typedef enum int {
        MOVE_STEADY,
        MOVE_NOISE,
        MOVE_HALF_FLIP,
        MOVE_HOLD
    } motion_kind_t;

    // one expected result word
    typedef struct {
        logic signed [STEP_W-1:0]  step;
        logic signed [TURNS_W-1:0] turns;
        logic signed [SPEED_W-1:0] speed_avg;
        logic signed [ANGLE_W-1:0] angle_q8;
    } estimate_t;

    // tracks shaft motion from accepted samples and checks the result words
    class shaft_motion_board;
        logic [SAMPLE_W-1:0] last_count;
        logic [TURNS_W-1:0]  turn_ctr;
        int                  step_hist [DEPTH];
        int                  hist_pos;
        longint              step_total;
        estimate_t           awaited[$];
        int                  faults;

        function new();
            last_count = '0;
            turn_ctr   = '0;
            foreach (step_hist[i]) step_hist[i] = 0;
            hist_pos   = 0;
            step_total = 0;
            faults     = 0;
        endfunction

        function void note_count(logic [SAMPLE_W-1:0] cur);
            int        diff;
            int        step_now;
            longint    shaft_pos;
            estimate_t est;
            diff = int'(cur) - int'(last_count);
            // wrap detection; a jump of 32767 either way is no wrap, one of 32768 wraps
            if (diff < -HALF_RANGE)
            begin
                turn_ctr = turn_ctr + 1'b1;
                step_now = diff + FULL_RANGE;
            end
            else if (diff > HALF_RANGE)
            begin
                turn_ctr = turn_ctr - 1'b1;
                step_now = diff - FULL_RANGE;
            end
            else
            begin
                step_now = diff;
            end
            last_count = cur;
            // moving window with running sum
            step_total = step_total - step_hist[hist_pos] + step_now;
            step_hist[hist_pos] = step_now;
            hist_pos = (hist_pos + 1) % DEPTH;
            // absolute position and scaling, truncated toward zero
            shaft_pos = longint'(cur) + longint'($signed(turn_ctr)) * FULL_RANGE;
            est.step      = STEP_W'(step_now);
            est.turns     = turn_ctr;
            est.speed_avg = SPEED_W'((step_total * SPEED_NUM) / (SPEED_DEN * DEPTH));
            est.angle_q8  = ANGLE_W'((shaft_pos * 256) / ANGLE_DIV);
            awaited.push_back(est);
        endfunction

        function void check_estimate(logic signed [STEP_W-1:0]  step,
                                     logic signed [TURNS_W-1:0] turns,
                                     logic signed [SPEED_W-1:0] speed_avg,
                                     logic signed [ANGLE_W-1:0] angle_q8);
            estimate_t est;
            if (awaited.size() == 0)
            begin
                $error("result word with no sample pending: step %0d turns %0d", step, turns);
                faults++;
                return;
            end
            est = awaited.pop_front();
            if (step !== est.step)
            begin
                $error("step mismatch: expected %0d, got %0d", est.step, step);
                faults++;
            end
            if (turns !== est.turns)
            begin
                $error("turns mismatch: expected %0d, got %0d", est.turns, turns);
                faults++;
            end
            if (speed_avg !== est.speed_avg)
            begin
                $error("speed_avg mismatch: expected %0d, got %0d", est.speed_avg, speed_avg);
                faults++;
            end
            if (angle_q8 !== est.angle_q8)
            begin
                $error("angle_q8 mismatch: expected %0d, got %0d", est.angle_q8, angle_q8);
                faults++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    qcse_in_if  sample_bus ();
    qcse_out_if result_bus ();

    quadrature_count_speed_estimator #(
        .AVG_DEPTH(DEPTH)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .samples(sample_bus),
        .results(result_bus)
    );

    shaft_motion_board board = new();

    int                  send_gap_odds;
    int                  recv_stall_odds;
    int                  stall_left;
    bit                  calm;
    logic [SAMPLE_W-1:0] cursor;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("CHECK FAILED");
        $finish;
    end

    // result side backpressure in random bursts
    always @(posedge clk)
    begin
        if (stall_left == 0 && recv_stall_odds != 0 && $urandom_range(1, recv_stall_odds) == 1)
            stall_left = $urandom_range(1, 13);
        if (stall_left != 0)
        begin
            result_bus.ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
        begin
            result_bus.ready <= 1'b1;
        end
    end

    // check every accepted result word
    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
            board.check_estimate(result_bus.step, result_bus.turns,
                                 result_bus.speed_avg, result_bus.angle_q8);
    end

    // offer one sample word, sometimes after a gap, and note it once taken
    task automatic send_count(input logic [SAMPLE_W-1:0] value);
        int gap;
        if (send_gap_odds != 0 && $urandom_range(1, send_gap_odds) == 1)
        begin
            gap = $urandom_range(1, 13);
            sample_bus.valid        <= 1'b0;
            sample_bus.count_sample <= SAMPLE_W'($urandom);
            repeat (gap) @(posedge clk);
        end
        sample_bus.valid        <= 1'b1;
        sample_bus.count_sample <= value;
        @(posedge clk);
        while (!sample_bus.ready) @(posedge clk);
        board.note_count(value);
    endtask

    // hold off the sender until every pending result has come out
    task automatic drain_results();
        sample_bus.valid <= 1'b0;
        while (board.awaited.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        int                  remaining;
        int                  seg_len;
        int                  velocity;
        int                  span;
        motion_kind_t        kind;
        rst_n                   = 1'b0;
        sample_bus.valid        = 1'b0;
        sample_bus.count_sample = '0;
        result_bus.ready        = 1'b0;
        stall_left              = 0;
        send_gap_odds           = 4;
        recv_stall_odds         = 4;
        calm                    = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: first sample wraps backward against zero, half range both ways,
        // full scale jumps, no-wrap limits, standing still
        send_count(16'hFFFF);
        send_count(16'h0000);
        send_count(16'h7FFF);
        send_count(16'h0000);
        send_count(16'h8000);
        send_count(16'h0000);
        send_count(16'hFFFF);
        send_count(16'hFFFF);
        send_count(16'h7FFF);
        send_count(16'h8000);
        send_count(16'hFFFF);
        send_count(16'h0000);
        send_count(16'h0000);
        send_count(16'h5555);
        send_count(16'hAAAA);
        send_count(16'h0001);
        send_count(16'hFFFE);
        send_count(16'h3039);
        drain_results();
        cursor = 16'h3039;

        // spin forward over about twenty turns, then back past zero turns
        repeat (SPIN_FWD)
        begin
            cursor = cursor + 16'd32767;
            send_count(cursor);
        end
        repeat (SPIN_BACK)
        begin
            cursor = cursor - 16'd32767;
            send_count(cursor);
        end

        // random motion segments
        remaining = RANDOM_ITEMS;
        while (remaining > 0)
        begin
            if (remaining <= CALM_ITEMS && !calm)
            begin
                calm            = 1'b1;
                send_gap_odds   = 0;
                recv_stall_odds = 0;
            end
            if (!calm)
            begin
                case ($urandom_range(0, 3))
                    0: send_gap_odds = 0;
                    1: send_gap_odds = 2;
                    2: send_gap_odds = 6;
                    default: send_gap_odds = 16;
                endcase
                case ($urandom_range(0, 3))
                    0: recv_stall_odds = 0;
                    1: recv_stall_odds = 3;
                    2: recv_stall_odds = 8;
                    default: recv_stall_odds = 20;
                endcase
                if ($urandom_range(0, 9) == 0)
                    drain_results();
            end
            seg_len = $urandom_range(4, 60);
            if (seg_len > remaining)
                seg_len = remaining;
            kind = motion_kind_t'($urandom_range(0, 3));
            span = $urandom_range(0, 15);
            velocity = $urandom_range(0, 1 << span);
            if (velocity > HALF_RANGE)
                velocity = HALF_RANGE;
            if ($urandom_range(0, 1) == 1)
                velocity = -velocity;
            repeat (seg_len)
            begin
                case (kind)
                    MOVE_STEADY:    cursor = cursor + SAMPLE_W'(velocity + $urandom_range(0, 4) - 2);
                    MOVE_NOISE:     cursor = SAMPLE_W'($urandom);
                    MOVE_HALF_FLIP: cursor = cursor + 16'h8000;
                    default:        cursor = cursor + SAMPLE_W'($urandom_range(0, 6) - 3);
                endcase
                send_count(cursor);
                remaining--;
            end
        end

        // wind down
        drain_results();
        repeat (LINGER) @(posedge clk);
        if (board.faults == 0 && board.awaited.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/qcse_pkg.sv
sv/qcse_if.sv
sv/qcse_cell.sv
sv/qcse_scale.sv
sv/quadrature_count_speed_estimator.sv
bench/quadrature_count_speed_estimator_tb.sv
